// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define QLSF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// property checked on every clock edge, reset included
`define QLSF_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/qlsf_pkg.sv =====
// ----------------------------------------------------------------------------
// qlsf_pkg
// types, widths and the solve program of the quadratic least-squares fit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qlsf_pkg;

   localparam int DEF_MAX_SAMPLES = 1024;
   localparam int MIN_SAMPLES     = 3;

   localparam int SMP_T_W = 12;
   localparam int SMP_Y_W = 16;

   localparam int CNT_W   = 11;
   localparam int S_T_W   = 22;
   localparam int S_T2_W  = 34;
   localparam int S_T3_W  = 44;
   localparam int S_T4_W  = 56;
   localparam int S_Y_W   = 26;
   localparam int S_TY_W  = 38;
   localparam int S_T2Y_W = 48;

   localparam int BIG_W   = 160;
   localparam int COEF_W  = 64;
   localparam int FRAC_W  = 32;
   localparam int MUL_STEPS = S_T4_W;

   localparam int QDEPTH  = 2;

   typedef struct packed {
      logic [CNT_W-1:0]          count;
      logic signed [S_T_W-1:0]   s_t;
      logic signed [S_T2_W-1:0]  s_t2;
      logic signed [S_T3_W-1:0]  s_t3;
      logic signed [S_T4_W-1:0]  s_t4;
      logic signed [S_Y_W-1:0]   s_y;
      logic signed [S_TY_W-1:0]  s_ty;
      logic signed [S_T2Y_W-1:0] s_t2y;
      logic                      ovf;
   } sums_type;

   typedef enum logic [1:0] {OP_SET, OP_ADD, OP_SUB} op_mode_type;

   typedef struct packed {
      op_mode_type mode;
      logic [3:0]  dst;
      logic [3:0]  xsel;
      logic [2:0]  ysel;
   } op_type;

   // operand codes: sums, then cofactor temporaries
   localparam logic [3:0] X_N    = 4'd0;
   localparam logic [3:0] X_T    = 4'd1;
   localparam logic [3:0] X_T2   = 4'd2;
   localparam logic [3:0] X_T3   = 4'd3;
   localparam logic [3:0] X_T4   = 4'd4;
   localparam logic [3:0] X_Y    = 4'd5;
   localparam logic [3:0] X_TY   = 4'd6;
   localparam logic [3:0] X_T2Y  = 4'd7;
   localparam logic [3:0] X_A00  = 4'd8;
   localparam logic [3:0] X_A01  = 4'd9;
   localparam logic [3:0] X_A02  = 4'd10;
   localparam logic [3:0] X_A11  = 4'd11;
   localparam logic [3:0] X_A12  = 4'd12;
   localparam logic [3:0] X_A22  = 4'd13;

   // temporary store slots
   localparam logic [3:0] TMP_A00 = 4'd0;
   localparam logic [3:0] TMP_A01 = 4'd1;
   localparam logic [3:0] TMP_A02 = 4'd2;
   localparam logic [3:0] TMP_A11 = 4'd3;
   localparam logic [3:0] TMP_A12 = 4'd4;
   localparam logic [3:0] TMP_A22 = 4'd5;
   localparam logic [3:0] TMP_DET = 4'd6;
   localparam logic [3:0] TMP_N0  = 4'd7;
   localparam logic [3:0] TMP_N1  = 4'd8;
   localparam logic [3:0] TMP_N2  = 4'd9;
   localparam int         NUM_TMP = 10;

   localparam int NUM_OPS = 24;
   localparam int PC_W    = 5;

   function automatic op_type mk_op(input op_mode_type mode, input logic [3:0] dst,
                                    input logic [3:0] xsel, input logic [3:0] ysel);
      op_type o;
      o.mode = mode;
      o.dst  = dst;
      o.xsel = xsel;
      o.ysel = ysel[2:0];
      return o;
   endfunction

   // adjugate of the symmetric normal matrix, determinant, then cramer numerators
   function automatic op_type prog_op(input logic [PC_W-1:0] pc);
      op_type o;
      case (pc)
         5'd0:    o = mk_op(OP_SET, TMP_A00, X_T4,  X_T2);
         5'd1:    o = mk_op(OP_SUB, TMP_A00, X_T3,  X_T3);
         5'd2:    o = mk_op(OP_SET, TMP_A01, X_T3,  X_T2);
         5'd3:    o = mk_op(OP_SUB, TMP_A01, X_T4,  X_T);
         5'd4:    o = mk_op(OP_SET, TMP_A02, X_T3,  X_T);
         5'd5:    o = mk_op(OP_SUB, TMP_A02, X_T2,  X_T2);
         5'd6:    o = mk_op(OP_SET, TMP_A11, X_T4,  X_N);
         5'd7:    o = mk_op(OP_SUB, TMP_A11, X_T2,  X_T2);
         5'd8:    o = mk_op(OP_SET, TMP_A12, X_T2,  X_T);
         5'd9:    o = mk_op(OP_SUB, TMP_A12, X_T3,  X_N);
         5'd10:   o = mk_op(OP_SET, TMP_A22, X_T2,  X_N);
         5'd11:   o = mk_op(OP_SUB, TMP_A22, X_T,   X_T);
         5'd12:   o = mk_op(OP_SET, TMP_DET, X_A00, X_N);
         5'd13:   o = mk_op(OP_ADD, TMP_DET, X_A01, X_T);
         5'd14:   o = mk_op(OP_ADD, TMP_DET, X_A02, X_T2);
         5'd15:   o = mk_op(OP_SET, TMP_N0,  X_A00, X_Y);
         5'd16:   o = mk_op(OP_ADD, TMP_N0,  X_A01, X_TY);
         5'd17:   o = mk_op(OP_ADD, TMP_N0,  X_A02, X_T2Y);
         5'd18:   o = mk_op(OP_SET, TMP_N1,  X_A01, X_Y);
         5'd19:   o = mk_op(OP_ADD, TMP_N1,  X_A11, X_TY);
         5'd20:   o = mk_op(OP_ADD, TMP_N1,  X_A12, X_T2Y);
         5'd21:   o = mk_op(OP_SET, TMP_N2,  X_A02, X_Y);
         5'd22:   o = mk_op(OP_ADD, TMP_N2,  X_A12, X_TY);
         5'd23:   o = mk_op(OP_ADD, TMP_N2,  X_A22, X_T2Y);
         default: o = mk_op(OP_SET, TMP_A00, X_N,   X_N);
      endcase
      return o;
   endfunction

   function automatic logic [BIG_W-1:0] big_abs(input logic signed [BIG_W-1:0] v);
      return v[BIG_W-1] ? BIG_W'(-v) : BIG_W'(v);
   endfunction

endpackage

// ===== rtl/qlsf_front.sv =====
// ----------------------------------------------------------------------------
// qlsf_front
// sample intake: power terms pipeline and running sums, when not stalled one sample per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlsf_front
   import qlsf_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic signed [SMP_T_W-1:0] smp_t,
   input  logic signed [SMP_Y_W-1:0] smp_y,
   input  logic                      req_tlast,
   output logic                      push,
   output sums_type                  push_data,
   input  logic                      q_ready
);

   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int T2W   = 24;
   localparam int TYW   = 28;
   localparam int T3W   = 35;
   localparam int T4W   = 46;
   localparam int T2YW  = 40;

   logic                       s1_v_ff, s1_last_ff;
   logic signed [SMP_T_W-1:0]  s1_t_ff;
   logic signed [SMP_Y_W-1:0]  s1_y_ff;
   logic signed [T2W-1:0]      s1_t2_ff;
   logic signed [TYW-1:0]      s1_ty_ff;

   logic                       s2_v_ff, s2_last_ff;
   logic signed [SMP_T_W-1:0]  s2_t_ff;
   logic signed [SMP_Y_W-1:0]  s2_y_ff;
   logic signed [T2W-1:0]      s2_t2_ff;
   logic signed [TYW-1:0]      s2_ty_ff;
   logic signed [T3W-1:0]      s2_t3_ff;
   logic signed [T4W-1:0]      s2_t4_ff;
   logic signed [T2YW-1:0]     s2_t2y_ff;

   logic [CW-1:0]              cnt_ff;
   logic                       ovf_ff;
   logic signed [S_T_W-1:0]    st_ff;
   logic signed [S_T2_W-1:0]   st2_ff;
   logic signed [S_T3_W-1:0]   st3_ff;
   logic signed [S_T4_W-1:0]   st4_ff;
   logic signed [S_Y_W-1:0]    sy_ff;
   logic signed [S_TY_W-1:0]   sty_ff;
   logic signed [S_T2Y_W-1:0]  st2y_ff;

   logic     adv;
   logic     take;
   logic     use_smp;
   sums_type nxt;

   assign adv        = !(s2_v_ff && s2_last_ff && !q_ready);
   assign req_tready = adv;
   assign take       = s2_v_ff && adv;
   assign use_smp    = cnt_ff < CW'(MAX_SAMPLES);

   always_comb begin
      nxt.count = CNT_W'(cnt_ff + CW'(use_smp));
      nxt.ovf   = ovf_ff | !use_smp;
      nxt.s_t   = st_ff   + (use_smp ? S_T_W'(s2_t_ff)     : '0);
      nxt.s_t2  = st2_ff  + (use_smp ? S_T2_W'(s2_t2_ff)   : '0);
      nxt.s_t3  = st3_ff  + (use_smp ? S_T3_W'(s2_t3_ff)   : '0);
      nxt.s_t4  = st4_ff  + (use_smp ? S_T4_W'(s2_t4_ff)   : '0);
      nxt.s_y   = sy_ff   + (use_smp ? S_Y_W'(s2_y_ff)     : '0);
      nxt.s_ty  = sty_ff  + (use_smp ? S_TY_W'(s2_ty_ff)   : '0);
      nxt.s_t2y = st2y_ff + (use_smp ? S_T2Y_W'(s2_t2y_ff) : '0);
   end

   assign push      = take && s2_last_ff;
   assign push_data = nxt;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_t_ff    <= smp_t;
         s1_y_ff    <= smp_y;
         s1_last_ff <= req_tlast;
         s1_t2_ff   <= T2W'(smp_t) * T2W'(smp_t);
         s1_ty_ff   <= TYW'(smp_t) * TYW'(smp_y);
         s2_t_ff    <= s1_t_ff;
         s2_y_ff    <= s1_y_ff;
         s2_last_ff <= s1_last_ff;
         s2_t2_ff   <= s1_t2_ff;
         s2_ty_ff   <= s1_ty_ff;
         s2_t3_ff   <= T3W'(s1_t2_ff) * T3W'(s1_t_ff);
         s2_t4_ff   <= T4W'(s1_t2_ff) * T4W'(s1_t2_ff);
         s2_t2y_ff  <= T2YW'(s1_t2_ff) * T2YW'(s1_y_ff);
      end
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         st_ff   <= '0;
         st2_ff  <= '0;
         st3_ff  <= '0;
         st4_ff  <= '0;
         sy_ff   <= '0;
         sty_ff  <= '0;
         st2y_ff <= '0;
      end else begin
         if (adv) begin
            s1_v_ff <= req_tvalid;
            s2_v_ff <= s1_v_ff;
         end
         if (take) begin
            if (s2_last_ff) begin
               cnt_ff  <= '0;
               ovf_ff  <= 1'b0;
               st_ff   <= '0;
               st2_ff  <= '0;
               st3_ff  <= '0;
               st4_ff  <= '0;
               sy_ff   <= '0;
               sty_ff  <= '0;
               st2y_ff <= '0;
            end else begin
               cnt_ff  <= CW'(nxt.count);
               ovf_ff  <= nxt.ovf;
               st_ff   <= nxt.s_t;
               st2_ff  <= nxt.s_t2;
               st3_ff  <= nxt.s_t3;
               st4_ff  <= nxt.s_t4;
               sy_ff   <= nxt.s_y;
               sty_ff  <= nxt.s_ty;
               st2y_ff <= nxt.s_t2y;
            end
         end
      end
   end

endmodule

// ===== rtl/qlsf_queue.sv =====
// ----------------------------------------------------------------------------
// qlsf_queue
// short fifo of finished data sets between intake and solver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlsf_queue
   import qlsf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  sums_type push_data,
   output logic     q_ready,
   output logic     q_valid,
   output sums_type q_data,
   input  logic     pop
);

   localparam int PW = $clog2(QDEPTH);

   sums_type          entry_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]       fill_ff;

   assign q_ready = fill_ff != (PW+1)'(QDEPTH);
   assign q_valid = fill_ff != '0;
   assign q_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QDEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QDEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

endmodule

// ===== rtl/qlsf_solver.sv =====
// ----------------------------------------------------------------------------
// qlsf_solver
// cramer solve with a bit-serial multiplier and divider, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlsf_solver
   import qlsf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  sums_type                  q_data,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [3*COEF_W-1:0]       rsp_tdata,
   output logic [1:0]                rsp_tuser
);

   typedef enum logic [3:0] {
      S_IDLE, S_OP_READ, S_OP_SETUP, S_MUL, S_MACC, S_RDDET, S_CHECK,
      S_RDNUM, S_DIV_LOAD, S_DIV, S_ROUND, S_SAT, S_OUT
   } state_type;

   localparam int MC_W  = $clog2(MUL_STEPS);
   localparam int DC_W  = $clog2(BIG_W);
   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   state_type                 state_ff;
   sums_type                  sums_ff;
   logic [PC_W-1:0]           pc_ff;
   logic [1:0]                k_ff;
   logic signed [BIG_W-1:0]   x_ff;
   logic [MUL_STEPS-1:0]      ymag_ff;
   logic                      yneg_ff;
   logic signed [BIG_W-1:0]   prod_ff;
   logic [MC_W-1:0]           mcnt_ff;
   logic [BIG_W-1:0]          dmag_ff;
   logic                      dneg_ff;
   logic                      qneg_ff;
   logic [BIG_W-1:0]          nmag_ff;
   logic [BIG_W-1:0]          rem_ff;
   logic [BIG_W-1:0]          quo_ff;
   logic [DC_W-1:0]           dcnt_ff;
   logic [COEF_W-1:0]         coef_ff [3];
   logic                      sing_ff;
   logic                      rsp_valid_ff;
   logic [3*COEF_W-1:0]       rsp_data_ff;
   logic [1:0]                rsp_user_ff;

   logic signed [BIG_W-1:0]   tmp_mem [NUM_TMP];
   logic signed [BIG_W-1:0]   rd_a_ff, rd_b_ff;
   logic [3:0]                rd_addr;
   logic                      rd_en;
   logic                      tmp_we;
   logic signed [BIG_W-1:0]   tmp_wd;

   op_type                    op;
   logic signed [BIG_W-1:0]   yval;
   logic signed [BIG_W-1:0]   base;
   logic                      sub_eff;
   logic [BIG_W:0]            rem_sh;
   logic [BIG_W:0]            rem_diff;
   logic                      ge;
   logic                      hi_set;
   logic [COEF_W-1:0]         sat_val;

   function automatic logic signed [BIG_W-1:0] sum_val(input sums_type s,
                                                       input logic [2:0] code);
      logic signed [BIG_W-1:0] v;
      case (code)
         X_N[2:0]:   v = BIG_W'({1'b0, s.count});
         X_T[2:0]:   v = BIG_W'(s.s_t);
         X_T2[2:0]:  v = BIG_W'(s.s_t2);
         X_T3[2:0]:  v = BIG_W'(s.s_t3);
         X_T4[2:0]:  v = BIG_W'(s.s_t4);
         X_Y[2:0]:   v = BIG_W'(s.s_y);
         X_TY[2:0]:  v = BIG_W'(s.s_ty);
         default:    v = BIG_W'(s.s_t2y);
      endcase
      return v;
   endfunction

   assign op      = prog_op(pc_ff);
   assign yval    = sum_val(sums_ff, op.ysel);
   assign pop     = (state_ff == S_IDLE) && q_valid;
   assign sub_eff = (op.mode == OP_SUB) ^ yneg_ff;
   assign base    = (op.mode == OP_SET) ? '0 : rd_b_ff;
   assign tmp_we  = state_ff == S_MACC;
   assign tmp_wd  = sub_eff ? base - prod_ff : base + prod_ff;
   assign rd_en   = (state_ff == S_OP_READ) || (state_ff == S_RDDET) || (state_ff == S_RDNUM);

   always_comb begin
      unique case (state_ff)
         S_OP_READ: rd_addr = {1'b0, op.xsel[2:0]};
         S_RDDET:   rd_addr = TMP_DET;
         default:   rd_addr = TMP_N0 + 4'(k_ff);
      endcase
   end

   assign rem_sh   = {rem_ff, nmag_ff[BIG_W-1]};
   assign rem_diff = rem_sh - {1'b0, dmag_ff};
   assign ge       = !rem_diff[BIG_W];
   assign hi_set   = (|quo_ff[BIG_W-1:COEF_W]) || quo_ff[COEF_W-1];

   always_comb begin
      if (qneg_ff) begin
         sat_val = hi_set ? COEF_MIN : COEF_W'(-quo_ff[COEF_W-1:0]);
      end else begin
         sat_val = hi_set ? COEF_MAX : quo_ff[COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (tmp_we) begin
         tmp_mem[op.dst] <= tmp_wd;
      end
      if (rd_en) begin
         rd_a_ff <= tmp_mem[rd_addr];
         rd_b_ff <= tmp_mem[op.dst];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  sums_ff  <= q_data;
                  pc_ff    <= '0;
                  state_ff <= S_OP_READ;
               end
            end
            S_OP_READ: begin
               state_ff <= S_OP_SETUP;
            end
            S_OP_SETUP: begin
               x_ff     <= op.xsel[3] ? rd_a_ff : sum_val(sums_ff, op.xsel[2:0]);
               ymag_ff  <= MUL_STEPS'(big_abs(yval));
               yneg_ff  <= yval[BIG_W-1];
               prod_ff  <= '0;
               mcnt_ff  <= MC_W'(MUL_STEPS-1);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff <= (prod_ff <<< 1) + (ymag_ff[MUL_STEPS-1] ? x_ff : '0);
               ymag_ff <= ymag_ff << 1;
               mcnt_ff <= mcnt_ff - 1'b1;
               if (mcnt_ff == '0) begin
                  state_ff <= S_MACC;
               end
            end
            S_MACC: begin
               if (pc_ff == PC_W'(NUM_OPS-1)) begin
                  state_ff <= S_RDDET;
               end else begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= S_OP_READ;
               end
            end
            S_RDDET: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               dmag_ff <= big_abs(rd_a_ff);
               dneg_ff <= rd_a_ff[BIG_W-1];
               k_ff    <= '0;
               if ((sums_ff.count < CNT_W'(MIN_SAMPLES)) || (rd_a_ff == '0)) begin
                  sing_ff    <= 1'b1;
                  coef_ff[0] <= '0;
                  coef_ff[1] <= '0;
                  coef_ff[2] <= '0;
                  state_ff   <= S_OUT;
               end else begin
                  sing_ff  <= 1'b0;
                  state_ff <= S_RDNUM;
               end
            end
            S_RDNUM: begin
               state_ff <= S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
               qneg_ff  <= rd_a_ff[BIG_W-1] ^ dneg_ff;
               nmag_ff  <= big_abs(rd_a_ff) << FRAC_W;
               rem_ff   <= '0;
               quo_ff   <= '0;
               dcnt_ff  <= DC_W'(BIG_W-1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= ge ? rem_diff[BIG_W-1:0] : rem_sh[BIG_W-1:0];
               quo_ff  <= {quo_ff[BIG_W-2:0], ge};
               nmag_ff <= nmag_ff << 1;
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == '0) begin
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               if ({rem_ff, 1'b0} >= {1'b0, dmag_ff}) begin
                  quo_ff <= quo_ff + 1'b1;
               end
               state_ff <= S_SAT;
            end
            S_SAT: begin
               coef_ff[k_ff] <= sat_val;
               if (k_ff == 2'd2) begin
                  state_ff <= S_OUT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_RDNUM;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {coef_ff[2], coef_ff[1], coef_ff[0]};
                  rsp_user_ff  <= {sums_ff.ovf, sing_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/quadratic_least_squares_fit.sv =====
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// least-squares fit of y = c0 + c1*t + c2*t^2 over a stream of samples
// ----------------------------------------------------------------------------
// Samples are taken at one per cycle and reach the running sums through a
// two-stage multiply pipeline. The sample marked last closes a data set; its
// sums go into a two-entry queue and intake carries on at once. The solver
// works one data set at a time with a single shared bit-serial multiplier
// (24 products) and a bit-serial divider (3 quotients). Intake stalls only
// when a data set closes while the queue holds two.
`timescale 1ns / 1ps

module quadratic_least_squares_fit
   import qlsf_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // sample_t, sample_y, zero pad
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*COEF_W-1:0]   rsp_tdata,   // coef_const, coef_linear, coef_square
   output logic [1:0]            rsp_tuser    // singular, overflowed
);

   logic     push;
   sums_type push_data;
   logic     q_ready;
   logic     q_valid;
   sums_type q_data;
   logic     pop;

   qlsf_front #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .smp_t      (req_tdata[SMP_T_W-1:0]),
      .smp_y      (req_tdata[SMP_T_W +: SMP_Y_W]),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_data  (push_data),
      .q_ready    (q_ready)
   );

   qlsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .q_ready   (q_ready),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (pop)
   );

   qlsf_solver u_solver (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/qlsf_checker.sv =====
// ----------------------------------------------------------------------------
// qlsf_checker
// port-level checks of the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qlsf_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   `QLSF_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `QLSF_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `QLSF_ASSERT(a_sing_zero, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
   `QLSF_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid)

endmodule

bind quadratic_least_squares_fit qlsf_checker u_qlsf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
